[hdl/rexu_pkg.sv]
package rexu_pkg;

   // Operation codes of the decoded instruction.
   typedef enum logic [4:0] {
      OP_NONE  = 5'd0,
      OP_MOV   = 5'd1,
      OP_ADD   = 5'd2,
      OP_ADDI  = 5'd3,
      OP_SUB   = 5'd4,
      OP_SUBI  = 5'd5,
      OP_AND   = 5'd6,
      OP_ANDI  = 5'd7,
      OP_OR    = 5'd8,
      OP_ORI   = 5'd9,
      OP_XOR   = 5'd10,
      OP_NOR   = 5'd11,
      OP_SLL   = 5'd12,
      OP_SRL   = 5'd13,
      OP_SRA   = 5'd14,
      OP_LW    = 5'd15,
      OP_SW    = 5'd16,
      OP_J     = 5'd17,
      OP_JR    = 5'd18,
      OP_BEQ   = 5'd19,
      OP_BNE   = 5'd20,
      OP_RET   = 5'd21,
      OP_NOP   = 5'd22,
      OP_PUSH  = 5'd23,
      OP_POP   = 5'd24,
      OP_LI    = 5'd25,
      OP_LA    = 5'd26,
      OP_JAL   = 5'd27,
      OP_JALR  = 5'd28,
      OP_MFLR  = 5'd29
   } op_type;

   localparam logic [31:0] WORD_BYTES = 32'd4;
   localparam logic [31:0] HALT_PC    = 32'hFFFF_FFFF;
   localparam logic [4:0]  REG_ZERO   = 5'd0;
   localparam logic [4:0]  REG_SP     = 5'd1;

   // One instruction as held in the execute register.
   typedef struct packed {
      op_type      op;
      logic [4:0]  ra;
      logic [4:0]  rb;
      logic [4:0]  rc;
      logic [31:0] imm;
      logic [9:0]  target;
      logic [9:0]  pc;
   } instr_type;

   // Register file write port: general entries and the stack pointer.
   typedef struct packed {
      logic        we;
      logic [4:0]  index;
      logic [31:0] value;
      logic        sp_we;
      logic [31:0] sp_value;
   } regwr_type;

   // Everything one instruction does, as worked out by the execute logic.
   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        reg_we;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      regwr_type   wr;
      logic        link_we;
      logic [31:0] link_value;
      logic        mem_acc;
      logic        mem_read;
      logic        mem_we;
      logic [31:0] mem_addr;
      logic [31:0] mem_value;
   } exec_type;

endpackage

[hdl/rexu_ram.sv]
module rexu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/rexu_regfile.sv]
module rexu_regfile #(
   parameter int          NUM_REGS = 32,
   parameter logic [31:0] SP_INIT  = 32'h0003_FFF0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [2:0][4:0]     rd_index,
   input  rexu_pkg::regwr_type wr,
   output logic [2:0][31:0]    rd_data,
   output logic [31:0]         sp
);
   import rexu_pkg::*;

   localparam int         AW   = $clog2(NUM_REGS);
   localparam logic [5:0] NREG = 6'(NUM_REGS);

   logic [NUM_REGS-1:0] written_ff;
   logic [31:0]         sp_ff;
   logic                last_we_ff;
   logic [4:0]          last_index_ff;
   logic [31:0]         last_value_ff;

   // Stack pointer lives in its own register; reset puts it at the stack top.
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= SP_INIT;
      end else if (wr.sp_we) begin
         sp_ff <= wr.sp_value;
      end
   end

   // Entries read as zero until first written.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr.we) begin
         written_ff[wr.index[AW-1:0]] <= 1'b1;
      end
   end

   // Most recent write, forwarded to an instruction whose read raced it.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_we_ff <= 1'b0;
      end else if (wr.we) begin
         last_we_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         last_index_ff <= wr.index;
         last_value_ff <= wr.value;
      end
   end

   // Three read ports, each a copy of the array written in step.
   for (genvar p = 0; p < 3; p++) begin : g_port
      logic [4:0]  index_ff;
      logic        valid_ff;
      logic [31:0] ram_q;

      rexu_ram #(
         .WIDTH (32),
         .DEPTH (NUM_REGS)
      ) u_copy (
         .clock   (clock),
         .wr_en   (wr.we),
         .wr_addr (wr.index[AW-1:0]),
         .wr_data (wr.value),
         .rd_en   (rd_en),
         .rd_addr (rd_index[p][AW-1:0]),
         .rd_data (ram_q)
      );

      always_ff @(posedge clock) begin
         if (rd_en) begin
            index_ff <= rd_index[p];
            valid_ff <= written_ff[rd_index[p][AW-1:0]];
         end
      end

      always_comb begin
         if ({1'b0, index_ff} >= NREG) begin
            rd_data[p] = '0;
         end else if (index_ff == REG_SP) begin
            rd_data[p] = sp_ff;
         end else if (last_we_ff && (last_index_ff == index_ff)) begin
            rd_data[p] = last_value_ff;
         end else if (valid_ff) begin
            rd_data[p] = ram_q;
         end else begin
            rd_data[p] = '0;
         end
      end
   end

   assign sp = sp_ff;

endmodule

[hdl/rexu_alu.sv]
module rexu_alu #(
   parameter int NUM_REGS = 32
) (
   input  rexu_pkg::instr_type ins,
   input  logic [31:0]         a,
   input  logic [31:0]         b,
   input  logic [31:0]         c,
   input  logic [31:0]         sp,
   input  logic [31:0]         link,
   input  logic [31:0]         load_data,
   output rexu_pkg::exec_type  ex
);
   import rexu_pkg::*;

   localparam logic [5:0] NREG = 6'(NUM_REGS);

   logic [31:0] pc_inc;
   logic [31:0] sp_dec;
   logic [31:0] sp_inc;
   logic [31:0] load_inc;
   logic [4:0]  sh;
   logic        ra_ok;
   logic        has_val;
   logic [31:0] val;

   assign pc_inc   = 32'(ins.pc) + 32'd1;
   assign sp_dec   = sp - WORD_BYTES;
   assign sp_inc   = sp + WORD_BYTES;
   assign load_inc = load_data + WORD_BYTES;
   assign sh       = ins.imm[4:0];
   assign ra_ok    = (ins.ra != REG_ZERO) && ({1'b0, ins.ra} < NREG);

   // Decode and execute one instruction.
   always_comb begin
      ex         = '0;
      ex.next_pc = pc_inc;
      has_val    = 1'b0;
      val        = '0;
      unique case (ins.op)
         OP_MOV:  begin val = b;            has_val = 1'b1; end
         OP_ADD:  begin val = b + c;        has_val = 1'b1; end
         OP_ADDI: begin val = b + ins.imm;  has_val = 1'b1; end
         OP_SUB:  begin val = b - c;        has_val = 1'b1; end
         OP_SUBI: begin val = b - ins.imm;  has_val = 1'b1; end
         OP_AND:  begin val = b & c;        has_val = 1'b1; end
         OP_ANDI: begin val = b & ins.imm;  has_val = 1'b1; end
         OP_OR:   begin val = b | c;        has_val = 1'b1; end
         OP_ORI:  begin val = b | ins.imm;  has_val = 1'b1; end
         OP_XOR:  begin val = b ^ c;        has_val = 1'b1; end
         OP_NOR:  begin val = ~(b | c);     has_val = 1'b1; end
         OP_SLL:  begin val = b << sh;      has_val = 1'b1; end
         OP_SRL:  begin val = b >> sh;      has_val = 1'b1; end
         OP_SRA:  begin val = 32'($signed(b) >>> sh); has_val = 1'b1; end
         OP_LW: begin
            ex.mem_acc  = 1'b1;
            ex.mem_read = 1'b1;
            ex.mem_addr = b + ins.imm;
            val         = load_data;
            has_val     = 1'b1;
         end
         OP_SW: begin
            ex.mem_acc   = 1'b1;
            ex.mem_we    = 1'b1;
            ex.mem_addr  = b + ins.imm;
            ex.mem_value = a;
         end
         OP_J:    ex.next_pc = 32'(ins.target);
         OP_JR:   ex.next_pc = a;
         OP_BEQ: begin
            if (a == b) begin
               ex.next_pc = 32'(ins.target);
            end
         end
         OP_BNE: begin
            if (a != b) begin
               ex.next_pc = 32'(ins.target);
            end
         end
         OP_RET:  ex.next_pc = link;
         OP_PUSH: begin
            ex.wr.sp_we    = 1'b1;
            ex.wr.sp_value = sp_dec;
            ex.mem_acc     = 1'b1;
            ex.mem_we      = 1'b1;
            ex.mem_addr    = sp_dec;
            ex.mem_value   = (ins.ra == REG_SP) ? sp_dec : a;
            ex.reg_we      = 1'b1;
            ex.reg_index   = REG_SP;
            ex.reg_value   = sp_dec;
         end
         OP_POP: begin
            // Popping into the stack pointer leaves the loaded word plus four.
            ex.mem_acc  = 1'b1;
            ex.mem_read = 1'b1;
            ex.mem_addr = sp;
            ex.wr.sp_we = 1'b1;
            if (ins.ra == REG_SP) begin
               ex.wr.sp_value = load_inc;
               ex.reg_we      = 1'b1;
               ex.reg_index   = REG_SP;
               ex.reg_value   = load_inc;
            end else begin
               ex.wr.sp_value = sp_inc;
               if (ra_ok) begin
                  ex.wr.we     = 1'b1;
                  ex.wr.index  = ins.ra;
                  ex.wr.value  = load_data;
                  ex.reg_we    = 1'b1;
                  ex.reg_index = ins.ra;
                  ex.reg_value = load_data;
               end
            end
         end
         OP_LI:   begin val = ins.imm;           has_val = 1'b1; end
         OP_LA:   begin val = 32'(ins.target);   has_val = 1'b1; end
         OP_JAL: begin
            ex.link_we    = 1'b1;
            ex.link_value = pc_inc;
            ex.next_pc    = ins.imm;
         end
         OP_JALR: begin
            ex.link_we    = 1'b1;
            ex.link_value = pc_inc;
            ex.next_pc    = a;
         end
         OP_MFLR: begin val = link; has_val = 1'b1; end
         default: ;
      endcase

      // Plain register results; the stack pointer has its own register.
      if (has_val && ra_ok) begin
         ex.reg_we    = 1'b1;
         ex.reg_index = ins.ra;
         ex.reg_value = val;
         if (ins.ra == REG_SP) begin
            ex.wr.sp_we    = 1'b1;
            ex.wr.sp_value = val;
         end else begin
            ex.wr.we    = 1'b1;
            ex.wr.index = ins.ra;
            ex.wr.value = val;
         end
      end

      ex.halted = (ex.next_pc == HALT_PC);
   end

endmodule

[hdl/risc_execute_unit.sv]
// Channel  Direction  Handshake            Beat
// req      in         req_valid/req_ready  op, ra, rb, rc, imm, target, cur_pc
// rsp      out        rsp_valid/rsp_ready  next_pc, halted, reg and memory writes
//
// One instruction per cycle while rsp is not stalled; lw and pop hold the
// execute register until the registered read port of the data memory returns
// their word. A result moves from the execute register to the output register.
// Reset clears control state, sets r1 to the stack top and the link register
// to all ones; data memory is not cleared. A stalled rsp holds the execute
// register, and req is still taken while a finished result waits.
module risc_execute_unit #(
   parameter int MEM_WORDS = 65536,
   parameter int NUM_REGS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_op,
   input  logic [4:0]  req_ra,
   input  logic [4:0]  req_rb,
   input  logic [4:0]  req_rc,
   input  logic signed [31:0] req_imm,
   input  logic [9:0]  req_target,
   input  logic [9:0]  req_cur_pc,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_next_pc,
   output logic        rsp_halted,
   output logic        rsp_reg_we,
   output logic [4:0]  rsp_reg_index,
   output logic signed [31:0] rsp_reg_value,
   output logic        rsp_mem_we,
   output logic [15:0] rsp_mem_word_index,
   output logic signed [31:0] rsp_mem_value
);
   import rexu_pkg::*;

   localparam int          MAW       = $clog2(MEM_WORDS);
   localparam logic [31:0] SP_INIT   = 32'((MEM_WORDS - 4) * 4);
   localparam logic [15:0] MIDX_MASK = (MEM_WORDS >= 65536) ? 16'hFFFF : 16'(MEM_WORDS - 1);

   instr_type        ins_ff;
   logic             ex_valid_ff;
   logic             phase_ff;
   logic [31:0]      link_ff;
   logic             rsp_valid_ff;
   logic [31:0]      next_pc_ff;
   logic             halted_ff;
   logic             reg_we_ff;
   logic [4:0]       reg_index_ff;
   logic [31:0]      reg_value_ff;
   logic             mem_we_ff;
   logic [15:0]      mem_index_ff;
   logic [31:0]      mem_value_ff;

   logic             accept;
   logic             out_free;
   logic             ex_done;
   logic             mem_issue;
   logic [2:0][4:0]  rd_index;
   logic [2:0][31:0] rd_data;
   logic [31:0]      sp;
   logic [31:0]      load_data;
   logic [MAW-1:0]   mem_word;
   exec_type         ex;

   // Handshake: the execute stage frees when its result moves to the output.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ex_done   = ex_valid_ff && out_free && (!ex.mem_read || phase_ff);
   assign req_ready = !ex_valid_ff || ex_done;
   assign accept    = req_valid && req_ready;
   assign mem_issue = ex_valid_ff && ex.mem_read && !phase_ff;

   // Execute register for the accepted beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         ins_ff.op     <= op_type'(req_op);
         ins_ff.ra     <= req_ra;
         ins_ff.rb     <= req_rb;
         ins_ff.rc     <= req_rc;
         ins_ff.imm    <= req_imm;
         ins_ff.target <= req_target;
         ins_ff.pc     <= req_cur_pc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
         phase_ff    <= 1'b0;
      end else if (accept) begin
         ex_valid_ff <= 1'b1;
         phase_ff    <= 1'b0;
      end else if (ex_done) begin
         ex_valid_ff <= 1'b0;
         phase_ff    <= 1'b0;
      end else if (mem_issue) begin
         phase_ff    <= 1'b1;
      end
   end

   // Register file, read as the beat is taken.
   assign rd_index = {req_rc, req_rb, req_ra};

   rexu_regfile #(
      .NUM_REGS (NUM_REGS),
      .SP_INIT  (SP_INIT)
   ) u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_index (rd_index),
      .wr       (ex_done ? ex.wr : regwr_type'('0)),
      .rd_data  (rd_data),
      .sp       (sp)
   );

   rexu_alu #(
      .NUM_REGS (NUM_REGS)
   ) u_alu (
      .ins       (ins_ff),
      .a         (rd_data[0]),
      .b         (rd_data[1]),
      .c         (rd_data[2]),
      .sp        (sp),
      .link      (link_ff),
      .load_data (load_data),
      .ex        (ex)
   );

   // Data memory: loads read in the first cycle, stores write on completion.
   assign mem_word = ex.mem_addr[MAW+1:2];

   rexu_ram #(
      .WIDTH (32),
      .DEPTH (MEM_WORDS)
   ) u_dmem (
      .clock   (clock),
      .wr_en   (ex_done && ex.mem_we),
      .wr_addr (mem_word),
      .wr_data (ex.mem_value),
      .rd_en   (mem_issue),
      .rd_addr (mem_word),
      .rd_data (load_data)
   );

   // Link register for calls and returns.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= HALT_PC;
      end else if (ex_done && ex.link_we) begin
         link_ff <= ex.link_value;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ex_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_done) begin
         next_pc_ff   <= ex.next_pc;
         halted_ff    <= ex.halted;
         reg_we_ff    <= ex.reg_we;
         reg_index_ff <= ex.reg_index;
         reg_value_ff <= ex.reg_value;
         mem_we_ff    <= ex.mem_we;
         mem_index_ff <= ex.mem_acc ? (ex.mem_addr[17:2] & MIDX_MASK) : 16'd0;
         mem_value_ff <= ex.mem_value;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_pc        = next_pc_ff;
   assign rsp_halted         = halted_ff;
   assign rsp_reg_we         = reg_we_ff;
   assign rsp_reg_index      = reg_index_ff;
   assign rsp_reg_value      = reg_value_ff;
   assign rsp_mem_we         = mem_we_ff;
   assign rsp_mem_word_index = mem_index_ff;
   assign rsp_mem_value      = mem_value_ff;

endmodule

[tb/risc_execute_unit_test.sv]
`timescale 1ns / 1ps

module risc_execute_unit_test;
   import rexu_pkg::*;

   localparam int MEM_WORDS    = 65536;
   localparam int NUM_REGS     = 32;
   localparam int PLAN         = 0;
   localparam int CHECK        = 1;
   localparam int RANDOM_ITEMS = 650;
   localparam int DRAIN_AT     = 400;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 80;
   localparam int SETTLE       = 16;
   localparam int CYCLE_LIMIT  = 400000;

   // Opcode values that the package leaves unnamed; the block treats them as no-ops.
   localparam logic [4:0] OP_SPARE_TOP = 5'd31;

   typedef struct {
      logic [4:0]  op;
      logic [4:0]  ra;
      logic [4:0]  rb;
      logic [4:0]  rc;
      logic [31:0] imm;
      logic [9:0]  target;
      logic [9:0]  cur_pc;
      bit          drain_first;
   } test_instr_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        reg_we;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_we;
      logic [15:0] mem_word_index;
      logic [31:0] mem_value;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [4:0]  req_op = '0;
   logic [4:0]  req_ra = '0;
   logic [4:0]  req_rb = '0;
   logic [4:0]  req_rc = '0;
   logic signed [31:0] req_imm = '0;
   logic [9:0]  req_target = '0;
   logic [9:0]  req_cur_pc = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [31:0] rsp_next_pc;
   logic        rsp_halted;
   logic        rsp_reg_we;
   logic [4:0]  rsp_reg_index;
   logic signed [31:0] rsp_reg_value;
   logic        rsp_mem_we;
   logic [15:0] rsp_mem_word_index;
   logic signed [31:0] rsp_mem_value;

   risc_execute_unit #(
      .MEM_WORDS(MEM_WORDS),
      .NUM_REGS (NUM_REGS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_ra            (req_ra),
      .req_rb            (req_rb),
      .req_rc            (req_rc),
      .req_imm           (req_imm),
      .req_target        (req_target),
      .req_cur_pc        (req_cur_pc),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_halted        (rsp_halted),
      .rsp_reg_we        (rsp_reg_we),
      .rsp_reg_index     (rsp_reg_index),
      .rsp_reg_value     (rsp_reg_value),
      .rsp_mem_we        (rsp_mem_we),
      .rsp_mem_word_index(rsp_mem_word_index),
      .rsp_mem_value     (rsp_mem_value)
   );

   always #2 clock = ~clock;

   // Architectural state, kept twice: once while the program is planned and
   // once as beats are taken by the block.
   logic [31:0] gpr        [2][NUM_REGS];
   logic [31:0] link_value [2];
   logic [31:0] dmem       [2][MEM_WORDS];
   bit          dmem_valid [2][MEM_WORDS];

   test_instr_type pending_q[$];
   outcome_type    expected_q[$];
   logic [15:0]    stored_words[$];
   test_instr_type offered;
   int          planned = 0;
   bit          drain_next = 1'b0;
   int          failures = 0;
   int          beats_sent = 0;
   int          beats_rcvd = 0;
   int          halts_seen = 0;
   int          stores_seen = 0;
   int          send_gap = 0;
   int          recv_gap = 0;
   int          hold_left = 0;
   int          cycles = 0;

   function automatic void clear_state(input int side);
      for (int i = 0; i < NUM_REGS; i++) gpr[side][i] = '0;
      gpr[side][REG_SP] = (MEM_WORDS - 4) * WORD_BYTES;
      link_value[side] = HALT_PC;
   endfunction

   // Carries out one instruction on the given copy of the state and returns
   // the next pc, the halt flag and the writes it made.
   function automatic void execute_instr(input int side, input test_instr_type it,
                                         output outcome_type r);
      logic [31:0] a, b, c, val, sp, addr, next;
      logic [4:0]  sh;
      logic        write_ra;
      a = gpr[side][it.ra];
      b = gpr[side][it.rb];
      c = gpr[side][it.rc];
      sh = it.imm[4:0];
      next = 32'(it.cur_pc) + 32'd1;
      addr = b + it.imm;
      val = '0;
      write_ra = 1'b0;
      r = '0;
      case (it.op)
         OP_MOV:  begin val = b;                  write_ra = 1'b1; end
         OP_ADD:  begin val = b + c;              write_ra = 1'b1; end
         OP_ADDI: begin val = b + it.imm;         write_ra = 1'b1; end
         OP_SUB:  begin val = b - c;              write_ra = 1'b1; end
         OP_SUBI: begin val = b - it.imm;         write_ra = 1'b1; end
         OP_AND:  begin val = b & c;              write_ra = 1'b1; end
         OP_ANDI: begin val = b & it.imm;         write_ra = 1'b1; end
         OP_OR:   begin val = b | c;              write_ra = 1'b1; end
         OP_ORI:  begin val = b | it.imm;         write_ra = 1'b1; end
         OP_XOR:  begin val = b ^ c;              write_ra = 1'b1; end
         OP_NOR:  begin val = ~(b | c);           write_ra = 1'b1; end
         OP_SLL:  begin val = b << sh;            write_ra = 1'b1; end
         OP_SRL:  begin val = b >> sh;            write_ra = 1'b1; end
         OP_SRA:  begin val = $signed(b) >>> sh;  write_ra = 1'b1; end
         OP_LW: begin
            r.mem_word_index = addr[17:2];
            val = dmem[side][addr[17:2]];
            write_ra = 1'b1;
         end
         OP_SW: begin
            r.mem_word_index = addr[17:2];
            dmem[side][addr[17:2]] = a;
            dmem_valid[side][addr[17:2]] = 1'b1;
            r.mem_we = 1'b1;
            r.mem_value = a;
         end
         OP_J:   next = 32'(it.target);
         OP_JR:  next = a;
         OP_BEQ: if (a == b) next = 32'(it.target);
         OP_BNE: if (a != b) next = 32'(it.target);
         OP_RET: next = link_value[side];
         // Push lowers the stack pointer first, so pushing r1 stores the new value.
         OP_PUSH: begin
            sp = gpr[side][REG_SP] - WORD_BYTES;
            gpr[side][REG_SP] = sp;
            r.mem_value = gpr[side][it.ra];
            r.mem_word_index = sp[17:2];
            dmem[side][sp[17:2]] = r.mem_value;
            dmem_valid[side][sp[17:2]] = 1'b1;
            r.mem_we = 1'b1;
            r.reg_we = 1'b1;
            r.reg_index = REG_SP;
            r.reg_value = sp;
         end
         // Pop loads, then raises the stack pointer; popping r1 reports load plus four.
         OP_POP: begin
            sp = gpr[side][REG_SP];
            r.mem_word_index = sp[17:2];
            if (it.ra != REG_ZERO) gpr[side][it.ra] = dmem[side][sp[17:2]];
            gpr[side][REG_SP] = gpr[side][REG_SP] + WORD_BYTES;
            if (it.ra != REG_ZERO) begin
               r.reg_we = 1'b1;
               r.reg_index = it.ra;
               r.reg_value = gpr[side][it.ra];
            end
         end
         OP_LI:   begin val = it.imm;             write_ra = 1'b1; end
         OP_LA:   begin val = 32'(it.target);     write_ra = 1'b1; end
         OP_JAL: begin
            link_value[side] = 32'(it.cur_pc) + 32'd1;
            next = it.imm;
         end
         OP_JALR: begin
            link_value[side] = 32'(it.cur_pc) + 32'd1;
            next = a;
         end
         OP_MFLR: begin val = link_value[side];   write_ra = 1'b1; end
         default: ;
      endcase
      if (write_ra && it.ra != REG_ZERO) begin
         gpr[side][it.ra] = val;
         r.reg_we = 1'b1;
         r.reg_index = it.ra;
         r.reg_value = val;
      end
      r.next_pc = next;
      r.halted = (next == HALT_PC);
   endfunction

   // Runs an instruction on the planning copy and queues it for the driver.
   function automatic void plan_instr(input test_instr_type it);
      outcome_type r;
      it.drain_first = drain_next;
      drain_next = 1'b0;
      execute_instr(PLAN, it, r);
      if (r.mem_we) stored_words.push_back(r.mem_word_index);
      pending_q.push_back(it);
      planned++;
   endfunction

   function automatic void add_instr(input logic [4:0] op, input logic [4:0] ra,
                                     input logic [4:0] rb, input logic [4:0] rc,
                                     input logic [31:0] imm, input logic [9:0] target);
      test_instr_type it;
      it.op = op;
      it.ra = ra;
      it.rb = rb;
      it.rc = rc;
      it.imm = imm;
      it.target = target;
      it.cur_pc = 10'($urandom_range(0, 1023));
      it.drain_first = 1'b0;
      plan_instr(it);
   endfunction

   // Register picks lean on a few low registers so results feed the next beats.
   function automatic logic [4:0] pick_reg();
      if ($urandom_range(0, 9) < 6) return 5'($urandom_range(0, 7));
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic logic [31:0] pick_imm();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return 32'($signed($urandom_range(0, 16)) - 8);
      if (roll < 45) return 32'($urandom_range(0, 31));
      if (roll < 55) begin
         case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0;
         endcase
      end
      return $urandom;
   endfunction

   // Points a load at a word that has been stored, with random upper address bits.
   function automatic void aim_load(inout test_instr_type it, input logic [15:0] word);
      logic [31:0] addr;
      addr = {14'($urandom), word, 2'($urandom)};
      it.imm = addr - gpr[PLAN][it.rb];
   endfunction

   // Any opcode with random fields; loads and pops go only to stored words.
   function automatic test_instr_type random_instr();
      test_instr_type it;
      it.op = 5'($urandom_range(0, 31));
      it.ra = pick_reg();
      it.rb = pick_reg();
      it.rc = pick_reg();
      it.imm = pick_imm();
      it.target = 10'($urandom_range(0, 1023));
      it.cur_pc = 10'($urandom_range(0, 1023));
      it.drain_first = 1'b0;
      if (it.op == OP_LW && stored_words.size() == 0) it.op = OP_SW;
      if (it.op == OP_LW)
         aim_load(it, stored_words[$urandom_range(0, stored_words.size() - 1)]);
      if (it.op == OP_POP && !dmem_valid[PLAN][gpr[PLAN][REG_SP][17:2]]) it.op = OP_PUSH;
      return it;
   endfunction

   function automatic int pick_gap(input int beat_no);
      int roll;
      if (beat_no % 160 < 40) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
         failures++;
      end
   endfunction

   // Driver: offers queued instructions, holding one back for a drain when marked.
   always @(posedge clock) begin : drive_req
      outcome_type predicted;
      logic        offer;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            execute_instr(CHECK, offered, predicted);
            expected_q.push_back(predicted);
            beats_sent++;
            offer = 1'b0;
            send_gap = pick_gap(beats_sent);
         end
         if (hold_left > 0) send_gap = 0;
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain_first && expected_q.size() > 0)) begin
               offered = pending_q.pop_front();
               offer = 1'b1;
               req_op <= offered.op;
               req_ra <= offered.ra;
               req_rb <= offered.rb;
               req_rc <= offered.rc;
               req_imm <= offered.imm;
               req_target <= offered.target;
               req_cur_pc <= offered.cur_pc;
            end
         end
         req_valid <= offer;
      end
   end

   // Monitor: checks each result beat and throttles rsp_ready, with one long hold.
   always @(posedge clock) begin : watch_rsp
      outcome_type want;
      logic        ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_rcvd++;
            if (rsp_halted) halts_seen++;
            if (rsp_mem_we) stores_seen++;
            if (expected_q.size() == 0) begin
               $error("result beat with no instruction outstanding");
               failures++;
            end else begin
               want = expected_q.pop_front();
               check_field("next_pc", want.next_pc, rsp_next_pc);
               check_field("halted", 32'(want.halted), 32'(rsp_halted));
               check_field("reg_we", 32'(want.reg_we), 32'(rsp_reg_we));
               check_field("reg_index", 32'(want.reg_index), 32'(rsp_reg_index));
               check_field("reg_value", want.reg_value, rsp_reg_value);
               check_field("mem_we", 32'(want.mem_we), 32'(rsp_mem_we));
               check_field("mem_word_index", 32'(want.mem_word_index),
                           32'(rsp_mem_word_index));
               check_field("mem_value", want.mem_value, rsp_mem_value);
            end
            if (beats_rcvd == HOLD_AT) hold_left = HOLD_CYCLES;
            else recv_gap = pick_gap(beats_rcvd + 80);
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("risc_execute_unit test failed");
         $finish;
      end
   end

   initial begin : stimulus
      test_instr_type it;
      int     n;
      int     roll;
      logic [4:0]  r_x;
      logic [4:0]  r_y;
      logic [31:0] v;

      clear_state(PLAN);
      clear_state(CHECK);

      // Directed: reset link halts, wrapping arithmetic, shift extremes, r0 writes,
      // stack with r1 itself, extreme addresses, every branch and call form.
      add_instr(OP_RET,  5'd0,  5'd0, 5'd0, 32'h0, 10'd0);
      add_instr(OP_MFLR, 5'd2,  5'd0, 5'd0, 32'h0, 10'd0);
      add_instr(OP_LI,   5'd2,  5'd0, 5'd0, 32'h7FFF_FFFF, 10'd0);
      add_instr(OP_LI,   5'd3,  5'd0, 5'd0, 32'h8000_0000, 10'd0);
      add_instr(OP_ADD,  5'd4,  5'd2, 5'd2, 32'h0, 10'd0);
      add_instr(OP_ADDI, 5'd5,  5'd2, 5'd0, 32'h1, 10'd0);
      add_instr(OP_SUB,  5'd6,  5'd0, 5'd3, 32'h0, 10'd0);
      add_instr(OP_SUBI, 5'd7,  5'd3, 5'd0, 32'h1, 10'd0);
      add_instr(OP_AND,  5'd8,  5'd2, 5'd4, 32'h0, 10'd0);
      add_instr(OP_ANDI, 5'd9,  5'd3, 5'd0, 32'hFFFF_FFFF, 10'd0);
      add_instr(OP_OR,   5'd10, 5'd2, 5'd3, 32'h0, 10'd0);
      add_instr(OP_ORI,  5'd11, 5'd0, 5'd0, 32'hFFFF_FFFF, 10'd0);
      add_instr(OP_XOR,  5'd12, 5'd3, 5'd2, 32'h0, 10'd0);
      add_instr(OP_NOR,  5'd13, 5'd0, 5'd0, 32'h0, 10'd0);
      add_instr(OP_SLL,  5'd14, 5'd2, 5'd0, 32'd31, 10'd0);
      add_instr(OP_SRL,  5'd15, 5'd3, 5'd0, 32'hFFFF_FFFF, 10'd0);
      add_instr(OP_SRA,  5'd16, 5'd3, 5'd0, 32'd31, 10'd0);
      add_instr(OP_SRA,  5'd17, 5'd3, 5'd0, 32'h0, 10'd0);
      add_instr(OP_MOV,  5'd0,  5'd2, 5'd0, 32'h0, 10'd0);
      add_instr(OP_PUSH, 5'd2,  5'd0, 5'd0, 32'h0, 10'd0);
      add_instr(OP_PUSH, 5'd1,  5'd0, 5'd0, 32'h0, 10'd0);
      add_instr(OP_POP,  5'd18, 5'd0, 5'd0, 32'h0, 10'd0);
      add_instr(OP_POP,  5'd1,  5'd0, 5'd0, 32'h0, 10'd0);
      add_instr(OP_SW,   5'd3,  5'd0, 5'd0, 32'h7FFF_FFFC, 10'd0);
      add_instr(OP_LW,   5'd31, 5'd0, 5'd0, 32'h7FFF_FFFF, 10'd0);
      add_instr(OP_J,    5'd0,  5'd0, 5'd0, 32'h0, 10'd1023);
      add_instr(OP_BEQ,  5'd0,  5'd0, 5'd0, 32'h0, 10'd0);
      add_instr(OP_BNE,  5'd0,  5'd0, 5'd0, 32'h0, 10'd1023);
      add_instr(OP_BNE,  5'd2,  5'd3, 5'd0, 32'h0, 10'd1023);
      add_instr(OP_LA,   5'd19, 5'd0, 5'd0, 32'h0, 10'd1023);
      add_instr(OP_JAL,  5'd0,  5'd0, 5'd0, 32'h7FFF_FFFF, 10'd0);
      add_instr(OP_RET,  5'd0,  5'd0, 5'd0, 32'h0, 10'd0);
      add_instr(OP_JALR, 5'd11, 5'd0, 5'd0, 32'h0, 10'd0);
      add_instr(OP_MFLR, 5'd20, 5'd0, 5'd0, 32'h0, 10'd0);
      add_instr(OP_JR,   5'd3,  5'd0, 5'd0, 32'h0, 10'd0);
      add_instr(OP_NOP,  5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 10'd1023);
      add_instr(OP_NONE, 5'd21, 5'd2, 5'd3, 32'h0, 10'd0);
      add_instr(OP_SPARE_TOP, 5'd22, 5'd2, 5'd3, 32'h0, 10'd0);

      // Random program: mostly well-formed sequences with random content, the rest
      // single instructions of any opcode. The sender drains once after the
      // directed part and again one or more times around DRAIN_AT, midway.
      drain_next = 1'b1;
      n = planned + RANDOM_ITEMS;
      while (planned < n) begin
         if (planned >= DRAIN_AT && planned < DRAIN_AT + 4) drain_next = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            plan_instr(random_instr());
         end else if (roll < 55) begin
            // Stack: a few pushes, then as many pops.
            roll = $urandom_range(1, 4);
            repeat (roll) add_instr(OP_PUSH, pick_reg(), 5'd0, 5'd0, 32'h0, 10'd0);
            repeat (roll) begin
               it = random_instr();
               it.op = dmem_valid[PLAN][gpr[PLAN][REG_SP][17:2]] ? OP_POP : OP_PUSH;
               plan_instr(it);
            end
         end else if (roll < 72) begin
            // Store, some unrelated work, then load the same word back.
            it = random_instr();
            it.op = OP_SW;
            plan_instr(it);
            repeat ($urandom_range(0, 2)) plan_instr(random_instr());
            it = random_instr();
            it.op = OP_LW;
            aim_load(it, stored_words[$]);
            plan_instr(it);
         end else if (roll < 86) begin
            // Call, body, read the link, return.
            it = random_instr();
            it.op = $urandom_range(0, 1) ? OP_JAL : OP_JALR;
            if (it.op == OP_JAL) it.imm = 32'($urandom_range(0, 1023));
            plan_instr(it);
            repeat ($urandom_range(0, 3)) plan_instr(random_instr());
            add_instr(OP_MFLR, pick_reg(), 5'd0, 5'd0, 32'h0, 10'd0);
            add_instr(OP_RET, 5'd0, 5'd0, 5'd0, 32'h0, 10'd0);
         end else begin
            // Compare: load two registers equal or not, then branch on them.
            r_x = 5'($urandom_range(1, 31));
            r_y = 5'($urandom_range(1, 31));
            v = pick_imm();
            add_instr(OP_LI, r_x, 5'd0, 5'd0, v, 10'd0);
            add_instr(OP_LI, r_y, 5'd0, 5'd0, $urandom_range(0, 1) ? v : v ^ 32'h1, 10'd0);
            add_instr($urandom_range(0, 1) ? OP_BEQ : OP_BNE, r_x, r_y, 5'd0, 32'h0,
                      10'($urandom_range(0, 1023)));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait until every planned instruction has come back as a result beat.
      do @(posedge clock);
      while (beats_rcvd < planned);
      repeat (SETTLE) @(posedge clock);

      $display("Ran %0d instructions of every opcode, including stack, load/store,",
               beats_sent);
      $display("call and branch sequences; %0d halts, %0d stores, one %0d-cycle rsp hold.",
               halts_seen, stores_seen, HOLD_CYCLES);
      if (failures == 0) begin
         $display("risc_execute_unit test passed");
      end else begin
         $display("risc_execute_unit test failed");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/rexu_pkg.sv
hdl/rexu_ram.sv
hdl/rexu_regfile.sv
hdl/rexu_alu.sv
hdl/risc_execute_unit.sv
tb/risc_execute_unit_test.sv
